[hw/rtl/frame_diff_histogram_similarity_unit_defines.svh]
// ----------------------------------------------------------------------------
// frame_diff_histogram_similarity_unit_defines
// assertion macros shared by the frame difference similarity unit
// ----------------------------------------------------------------------------
`ifndef FRAME_DIFF_HISTOGRAM_SIMILARITY_UNIT_DEFINES_SVH
`define FRAME_DIFF_HISTOGRAM_SIMILARITY_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define FDHS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FDHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/fdhs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdhs_pkg
// types, constants and the bin weight table of the similarity unit
// ----------------------------------------------------------------------------
package fdhs_pkg;

    localparam int unsigned PIX_W    = 8;
    localparam int unsigned BIN_W    = 5;
    localparam int unsigned WEIGHT_W = 20;
    localparam int unsigned ZCNT_W   = 13;
    localparam int unsigned SUM_W    = 32;
    localparam int unsigned THR_W    = 24;

    localparam logic [THR_W-1:0] THR_RESET = 24'd8388608;
    localparam logic [PIX_W-1:0] DIFF_OUT_OF_RANGE = 8'd255;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_a;
        logic [PIX_W-1:0] pixel_b;
        logic             last_pixel;
    } pixel_in_t;

    typedef struct packed {
        logic              is_similar;
        logic [ZCNT_W-1:0] zero_bin_count;
        logic [SUM_W-1:0]  weighted_sum_tenths;
    } result_t;

    // frame totals handed from the accumulator to the compare pipeline
    typedef struct packed {
        logic [ZCNT_W-1:0] zero_count;
        logic [SUM_W-1:0]  weight_sum;
    } frame_tot_t;

    // bin weights scaled by ten
    function automatic logic [WEIGHT_W-1:0] bin_weight(input logic [BIN_W-1:0] bin);
        logic [WEIGHT_W-1:0] w;
        case (bin)
            5'd0:    w = 20'd10;
            5'd1:    w = 20'd15;
            5'd2:    w = 20'd21;
            5'd3:    w = 20'd30;
            5'd4:    w = 20'd44;
            5'd5:    w = 20'd64;
            5'd6:    w = 20'd93;
            5'd7:    w = 20'd135;
            5'd8:    w = 20'd195;
            5'd9:    w = 20'd282;
            5'd10:   w = 20'd410;
            5'd11:   w = 20'd590;
            5'd12:   w = 20'd860;
            5'd13:   w = 20'd1240;
            5'd14:   w = 20'd1810;
            5'd15:   w = 20'd2620;
            5'd16:   w = 20'd3800;
            5'd17:   w = 20'd5500;
            5'd18:   w = 20'd8000;
            5'd19:   w = 20'd11600;
            5'd20:   w = 20'd16800;
            5'd21:   w = 20'd24400;
            5'd22:   w = 20'd35400;
            5'd23:   w = 20'd51200;
            5'd24:   w = 20'd74300;
            5'd25:   w = 20'd100000;
            5'd26:   w = 20'd150000;
            5'd27:   w = 20'd230000;
            5'd28:   w = 20'd330000;
            5'd29:   w = 20'd475000;
            5'd30:   w = 20'd690000;
            5'd31:   w = 20'd1000000;
            default: w = 20'd0;
        endcase
        return w;
    endfunction

endpackage

[hw/rtl/fdhs_accum.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdhs_accum
// per-pixel difference binning and saturating frame accumulators
// ----------------------------------------------------------------------------
module fdhs_accum import fdhs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  pixel_in_t  pix,
    input  logic       take,
    output frame_tot_t tot
);

    logic [ZCNT_W-1:0]   zero_acc_reg, zero_acc_next;
    logic [SUM_W-1:0]    sum_acc_reg, sum_acc_next;
    logic [PIX_W-1:0]    diff;
    logic [BIN_W-1:0]    bin;
    logic                counted;
    logic [WEIGHT_W-1:0] weight;
    logic [SUM_W:0]      sum_wide;
    frame_tot_t          upd;

    // floor(d*32/255) equals d>>3 for every d below 255
    always_comb begin
        diff    = (pix.pixel_a > pix.pixel_b) ? (pix.pixel_a - pix.pixel_b)
                                              : (pix.pixel_b - pix.pixel_a);
        bin     = diff[PIX_W-1 -: BIN_W];
        counted = (diff != DIFF_OUT_OF_RANGE);
        weight  = bin_weight(bin);

        sum_wide = {1'b0, sum_acc_reg} + {{(SUM_W + 1 - WEIGHT_W){1'b0}}, weight};
        upd      = '{zero_count: zero_acc_reg, weight_sum: sum_acc_reg};
        if (counted) begin
            upd.weight_sum = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
            if (bin == '0 && zero_acc_reg != '1) begin
                upd.zero_count = zero_acc_reg + ZCNT_W'(1);
            end
        end
        tot = upd;

        zero_acc_next = zero_acc_reg;
        sum_acc_next  = sum_acc_reg;
        if (take) begin
            if (pix.last_pixel) begin
                zero_acc_next = '0;
                sum_acc_next  = '0;
            end else begin
                zero_acc_next = upd.zero_count;
                sum_acc_next  = upd.weight_sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_acc_reg <= '0;
            sum_acc_reg  <= '0;
        end else begin
            zero_acc_reg <= zero_acc_next;
            sum_acc_reg  <= sum_acc_next;
        end
    end

endmodule

[hw/rtl/frame_diff_histogram_similarity_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_diff_histogram_similarity_unit
// frame difference histogram with weighted similarity decision
// ----------------------------------------------------------------------------
// Takes one pixel pair transaction per clock while no last pair is stalled.
// Each pair is registered, its absolute difference is binned and the bin
// weight (times ten) and the zero-bin count are accumulated in fdhs_accum,
// which sets the rate of one pair per cycle. The pair flagged last_pixel
// closes the frame: its totals are registered and move through two compare
// stages (partial products of threshold times sum, then the 56-bit compare)
// into the output register, where a result transaction is offered. Pairs
// keep being accepted while a result waits on m_ready; only a full compare
// pipeline holds back the next frame's last pair. Writes to the threshold
// are expected while no frame is in flight.
// ----------------------------------------------------------------------------

`include "frame_diff_histogram_similarity_unit_defines.svh"

module frame_diff_histogram_similarity_unit import fdhs_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    // pixel pair channel
    input  logic             s_valid,
    output logic             s_ready,
    input  pixel_in_t        s_data,
    // frame result channel
    output logic             m_valid,
    input  logic             m_ready,
    output result_t          m_data,
    // threshold register
    input  logic             cfg_wr_en,
    input  logic [THR_W-1:0] cfg_wr_data
);

    localparam int unsigned Z10_W = ZCNT_W + 4;          // zero count times ten
    localparam int unsigned PP_W  = THR_W + SUM_W / 2;   // one partial product
    localparam int unsigned CMP_W = THR_W + SUM_W;       // full product width

    // threshold register
    logic [THR_W-1:0] thr_reg, thr_next;

    // input register
    logic      p1_valid_reg, p1_valid_next;
    pixel_in_t p1_pix_reg, p1_pix_next;

    // frame totals
    logic       p2_valid_reg, p2_valid_next;
    frame_tot_t p2_tot_reg, p2_tot_next;

    // partial products
    logic              p3_valid_reg, p3_valid_next;
    frame_tot_t        p3_tot_reg, p3_tot_next;
    logic [Z10_W-1:0]  p3_z10_reg, p3_z10_next;
    logic [PP_W-1:0]   p3_pp_lo_reg, p3_pp_lo_next;
    logic [PP_W-1:0]   p3_pp_hi_reg, p3_pp_hi_next;

    // output register
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;

    // stage flow control
    logic       out_free, p3_free, p2_free, p1_take;
    frame_tot_t acc_tot;
    logic [CMP_W-1:0] lhs, rhs;

    fdhs_accum u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .pix     (p1_pix_reg),
        .take    (p1_take),
        .tot     (acc_tot)
    );

    // a stage can load when it is empty or its content moves on this cycle
    always_comb begin
        out_free = !out_valid_reg || m_ready;
        p3_free  = !p3_valid_reg || out_free;
        p2_free  = !p2_valid_reg || p3_free;
        // non-final pairs only touch the accumulators and never stall
        p1_take  = p1_valid_reg && (!p1_pix_reg.last_pixel || p2_free);
        s_ready  = !p1_valid_reg || p1_take;
    end

    always_comb begin
        thr_next = cfg_wr_en ? cfg_wr_data : thr_reg;

        // input register
        p1_valid_next = p1_valid_reg;
        p1_pix_next   = p1_pix_reg;
        if (s_ready) begin
            p1_valid_next = s_valid;
            p1_pix_next   = s_data;
        end

        // frame totals, captured on the last pair
        p2_valid_next = p2_valid_reg;
        p2_tot_next   = p2_tot_reg;
        if (p2_free) begin
            p2_valid_next = p1_take && p1_pix_reg.last_pixel;
            p2_tot_next   = acc_tot;
        end

        // zero*10*2^24 against thr*sum, sum split in 16-bit halves
        p3_valid_next = p3_valid_reg;
        p3_tot_next   = p3_tot_reg;
        p3_z10_next   = p3_z10_reg;
        p3_pp_lo_next = p3_pp_lo_reg;
        p3_pp_hi_next = p3_pp_hi_reg;
        if (p3_free) begin
            p3_valid_next = p2_valid_reg;
            p3_tot_next   = p2_tot_reg;
            p3_z10_next   = {1'b0, p2_tot_reg.zero_count, 3'b000}
                          + {3'b000, p2_tot_reg.zero_count, 1'b0};
            p3_pp_lo_next = PP_W'(thr_reg) * PP_W'(p2_tot_reg.weight_sum[SUM_W/2-1:0]);
            p3_pp_hi_next = PP_W'(thr_reg) * PP_W'(p2_tot_reg.weight_sum[SUM_W-1:SUM_W/2]);
        end

        lhs = {{(CMP_W - Z10_W - THR_W){1'b0}}, p3_z10_reg, {THR_W{1'b0}}};
        rhs = {{(CMP_W - PP_W){1'b0}}, p3_pp_lo_reg}
            + {p3_pp_hi_reg, {(SUM_W/2){1'b0}}};

        // output register
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_free) begin
            out_valid_next = p3_valid_reg;
            // an empty frame has a zero sum and never reads as similar
            out_data_next.is_similar          = (p3_tot_reg.weight_sum != '0) && (lhs > rhs);
            out_data_next.zero_bin_count      = p3_tot_reg.zero_count;
            out_data_next.weighted_sum_tenths = p3_tot_reg.weight_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg       <= THR_RESET;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            thr_reg       <= thr_next;
            p1_valid_reg  <= p1_valid_next;
            p2_valid_reg  <= p2_valid_next;
            p3_valid_reg  <= p3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers need no reset
    always_ff @(posedge aclk) begin
        p1_pix_reg    <= p1_pix_next;
        p2_tot_reg    <= p2_tot_next;
        p3_tot_reg    <= p3_tot_next;
        p3_z10_reg    <= p3_z10_next;
        p3_pp_lo_reg  <= p3_pp_lo_next;
        p3_pp_hi_reg  <= p3_pp_hi_next;
        out_data_reg  <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // a similar frame must have counted pixels in bin zero
    `FDHS_ASSERT_NOW(a_similar_has_counts, aclk, aresetn, m_valid && m_data.is_similar, (m_data.weighted_sum_tenths != '0) && (m_data.zero_bin_count != '0), "similar flag without counted pixels")
    // a blocked last pair holds off the input channel
    `FDHS_ASSERT_NOW(a_last_stalls_input, aclk, aresetn, p1_valid_reg && p1_pix_reg.last_pixel && !p2_free, !s_ready, "input accepted over a stalled last pair")
    // frame totals are not lost while the compare stage is busy
    `FDHS_ASSERT_NEXT(a_totals_held, aclk, aresetn, p2_valid_reg && !p3_free, p2_valid_reg && $stable(p2_tot_reg), "frame totals dropped under stall")

endmodule
